// ----- rtl/core/tcw_pkg.sv -----
package tcw_pkg;

    // field widths of the transaction payloads
    localparam int OPC_W  = 1;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CELL_W-1:0] t_cell;

    // opcodes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // cell contents
    localparam t_cell BLANK_CELL = 16'h0720;
    localparam t_char TEXT_ATTR  = 8'h07;

    // special characters
    localparam t_char CH_NUL     = 8'd0;
    localparam t_char CH_NEWLINE = 8'd10;
    localparam t_char CH_RETURN  = 8'd13;

endpackage

// ----- rtl/core/tcw_if.sv -----
// request channel: one put or read per transaction
interface tcw_in_if;
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    tcw_pkg::t_char       character;
    tcw_pkg::t_row        read_row;
    tcw_pkg::t_col        read_col;

    modport source (output valid, opcode, character, read_row, read_col, input ready);
    modport sink   (input valid, opcode, character, read_row, read_col, output ready);
endinterface

// response channel: cursor position and cell contents
interface tcw_out_if;
    logic                 valid;
    logic                 ready;
    tcw_pkg::t_pos        cursor_pos;
    tcw_pkg::t_cell       cell_data;

    modport source (output valid, cursor_pos, cell_data, input ready);
    modport sink   (input valid, cursor_pos, cell_data, output ready);
endinterface

// ----- rtl/core/tcw_ram.sv -----
module tcw_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/core/tcw_addr_unit.sv -----
module tcw_addr_unit #(
    parameter int COLS   = 80,
    parameter int ADDR_W = 11
) (
    input  tcw_pkg::t_row     i_row,
    input  tcw_pkg::t_col     i_col,
    output logic [ADDR_W-1:0] o_addr
);

    // linear cell address: row times a constant column count plus column
    assign o_addr = ADDR_W'(int'(i_row) * COLS + int'(i_col));

endmodule

// ----- rtl/core/text_console_writer.sv -----
// text console writer
// Keeps a ROWS x COLS screen of 16-bit cells (attribute high, character low)
// and a cursor. Requests arrive on i_req: opcode put prints one character
// byte, opcode read fetches one cell at read_row/read_col. Every request
// gives exactly one response on o_rsp carrying the cursor position
// row*COLS+col (low 11 bits) and, for a read, the cell (zero for a put or
// an out-of-range read).
// After reset the cursor is at the top left and a clearing pass writes the
// blank cell into every screen location, one per cycle, with i_req.ready
// low throughout. A request is taken, decoded and executed through the
// single screen memory port pair and one shared address unit: a put passes
// DECODE, PUT (skipped for a zero byte) and FINISH, an in-range read
// DECODE, READ, RDATA and FINISH; FINISH loads the response register and
// the next request is taken only back in IDLE.
// A non-zero put while the cursor sits past the bottom row first scrolls:
// it copies rows 1 to ROWS-1 one row up, flushes the last copied cell and
// blanks the bottom row, all through the same address unit.
// The response sits in an output register; one further request is accepted
// while it waits, and that request's result is held until the receiver
// takes the first one.
module text_console_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcw_in_if.sink        i_req,
    tcw_out_if.source     o_rsp
);

    localparam int DEPTH = ROWS * COLS;
    localparam int MA_W  = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_RDATA,
        ST_SCR_COPY,
        ST_SCR_FLUSH,
        ST_SCR_BLANK,
        ST_PUT,
        ST_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic                r_opc, n_opc;
    tcw_pkg::t_char      r_ch, n_ch;
    tcw_pkg::t_row       r_rrow, n_rrow;
    tcw_pkg::t_col       r_rcol, n_rcol;
    tcw_pkg::t_row       r_row, n_row;
    tcw_pkg::t_col       r_col, n_col;
    logic [PW-1:0]       r_pos, n_pos;
    tcw_pkg::t_row       r_sr, n_sr;
    tcw_pkg::t_col       r_sc, n_sc;
    logic                r_cp_pend, n_cp_pend;
    logic [MA_W-1:0]     r_cp_addr, n_cp_addr;
    logic [MA_W-1:0]     r_clr, n_clr;
    tcw_pkg::t_cell      r_cell, n_cell;
    logic                r_out_valid, n_out_valid;
    tcw_pkg::t_pos       r_out_pos, n_out_pos;
    tcw_pkg::t_cell      r_out_cell, n_out_cell;

    tcw_pkg::t_row       u_row;
    tcw_pkg::t_col       u_col;
    logic [MA_W-1:0]     u_addr;

    logic                ram_we;
    logic [MA_W-1:0]     ram_waddr;
    tcw_pkg::t_cell      ram_wdata;
    tcw_pkg::t_cell      ram_rdata;

    // shared address unit
    tcw_addr_unit #(
        .COLS   (COLS),
        .ADDR_W (MA_W)
    ) u_addr_unit (
        .i_row  (u_row),
        .i_col  (u_col),
        .o_addr (u_addr)
    );

    // screen memory
    tcw_ram #(
        .WIDTH  (tcw_pkg::CELL_W),
        .DEPTH  (DEPTH),
        .ADDR_W (MA_W)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (u_addr),
        .o_rdata (ram_rdata)
    );

    // handshake outputs
    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cursor_pos = r_out_pos;
    assign o_rsp.cell_data  = r_out_cell;

    // address unit operand select
    always_comb begin
        case (r_state)
            ST_SCR_COPY: begin
                u_row = r_sr;
                u_col = r_sc;
            end
            ST_SCR_BLANK: begin
                u_row = tcw_pkg::ROW_W'(ROWS - 1);
                u_col = r_sc;
            end
            default: begin
                u_row = r_rrow;
                u_col = r_rcol;
            end
        endcase
    end

    // sequencer next state and memory write port
    always_comb begin
        n_state     = r_state;
        n_opc       = r_opc;
        n_ch        = r_ch;
        n_rrow      = r_rrow;
        n_rcol      = r_rcol;
        n_row       = r_row;
        n_col       = r_col;
        n_pos       = r_pos;
        n_sr        = r_sr;
        n_sc        = r_sc;
        n_cp_pend   = r_cp_pend;
        n_cp_addr   = r_cp_addr;
        n_clr       = r_clr;
        n_cell      = r_cell;
        n_out_valid = r_out_valid;
        n_out_pos   = r_out_pos;
        n_out_cell  = r_out_cell;
        ram_we      = 1'b0;
        ram_waddr   = r_cp_addr - MA_W'(COLS);
        ram_wdata   = ram_rdata;

        // response register drains independently
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = tcw_pkg::BLANK_CELL;
                if (r_clr == MA_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_opc   = i_req.opcode;
                    n_ch    = i_req.character;
                    n_rrow  = i_req.read_row;
                    n_rcol  = i_req.read_col;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_cell = '0;
                if (r_opc == tcw_pkg::OP_READ) begin
                    if (int'(r_rrow) < ROWS && int'(r_rcol) < COLS) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else if (r_ch == tcw_pkg::CH_NUL) begin
                    n_state = ST_FINISH;
                end else if (int'(r_row) >= ROWS) begin
                    n_sr      = tcw_pkg::ROW_W'(1);
                    n_sc      = '0;
                    n_cp_pend = 1'b0;
                    n_state   = ST_SCR_COPY;
                end else begin
                    n_state = ST_PUT;
                end
            end
            ST_READ: begin
                n_state = ST_RDATA;
            end
            ST_RDATA: begin
                n_cell  = ram_rdata;
                n_state = ST_FINISH;
            end
            ST_SCR_COPY: begin
                // write the cell fetched last cycle one row up, fetch the next
                ram_we    = r_cp_pend;
                n_cp_pend = 1'b1;
                n_cp_addr = u_addr;
                if (r_sc == tcw_pkg::COL_W'(COLS - 1)) begin
                    n_sc = '0;
                    if (r_sr == tcw_pkg::ROW_W'(ROWS - 1)) begin
                        n_state = ST_SCR_FLUSH;
                    end else begin
                        n_sr = r_sr + 1'b1;
                    end
                end else begin
                    n_sc = r_sc + 1'b1;
                end
            end
            ST_SCR_FLUSH: begin
                ram_we    = 1'b1;
                n_cp_pend = 1'b0;
                n_sc      = '0;
                n_state   = ST_SCR_BLANK;
            end
            ST_SCR_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = u_addr;
                ram_wdata = tcw_pkg::BLANK_CELL;
                if (r_sc == tcw_pkg::COL_W'(COLS - 1)) begin
                    n_row   = tcw_pkg::ROW_W'(ROWS - 1);
                    n_pos   = r_pos - PW'(COLS);
                    n_state = ST_PUT;
                end else begin
                    n_sc = r_sc + 1'b1;
                end
            end
            ST_PUT: begin
                if (r_ch == tcw_pkg::CH_NEWLINE) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                    n_pos = PW'(int'(r_pos) + COLS - int'(r_col));
                end else if (r_ch != tcw_pkg::CH_RETURN) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos[MA_W-1:0];
                    ram_wdata = {tcw_pkg::TEXT_ATTR, r_ch};
                    n_pos     = r_pos + 1'b1;
                    if (int'(r_col) + 1 >= COLS) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = tcw_pkg::POS_W'(r_pos);
                    n_out_cell  = r_cell;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_pos       <= '0;
            r_cp_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_pos       <= n_pos;
            r_cp_pend   <= n_cp_pend;
            r_out_valid <= n_out_valid;
        end
        r_opc      <= n_opc;
        r_ch       <= n_ch;
        r_rrow     <= n_rrow;
        r_rcol     <= n_rcol;
        r_sr       <= n_sr;
        r_sc       <= n_sc;
        r_cp_addr  <= n_cp_addr;
        r_cell     <= n_cell;
        r_out_pos  <= n_out_pos;
        r_out_cell <= n_out_cell;
    end

endmodule

// ----- rtl/core/tcw_checker.sv -----
module tcw_checker #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input tcw_pkg::t_pos  i_cursor_pos,
    input tcw_pkg::t_cell i_cell_data
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    // outstanding transactions: accepted requests minus delivered responses
    always_comb begin
        n_cnt = r_cnt;
        if (i_in_valid && i_in_ready && !(i_out_valid && i_out_ready)) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!(i_in_valid && i_in_ready) && i_out_valid && i_out_ready) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // reset starts the clearing pass with no request taken
    a_reset_blocks_req: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("request or response active right after reset");

    // every response belongs to an accepted request, at most two in flight
    a_resp_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_cnt != 2'd0) && (r_cnt != 2'd3))
        else $error("response without a matching request");

    // cursor never goes beyond one past the last cell
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (ROWS * COLS > 2047) || (int'(i_cursor_pos) <= ROWS * COLS))
        else $error("cursor position out of range");

    // stalled response holds its payload
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_cursor_pos) && $stable(i_cell_data))
        else $error("stalled response changed");

endmodule

bind text_console_writer tcw_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_cursor_pos (o_rsp.cursor_pos),
    .i_cell_data  (o_rsp.cell_data)
);

// ----- tb/tb_top.sv -----
module tb_top;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    // clearing pass plus ~430 transactions, each allowed a full scroll and stalls, times four
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_ITEMS = 400;

    typedef struct packed {
        tcw_pkg::t_pos  pos;
        tcw_pkg::t_cell data;
    } t_console_rsp;

    // screen and cursor tracker; predicts one response per request
    class console_checker;
        tcw_pkg::t_cell screen [ROWS*COLS];
        int             cur_row;
        int             cur_col;
        t_console_rsp   awaited_rsp [$];
        int             failures;

        function new();
            foreach (screen[i]) screen[i] = tcw_pkg::BLANK_CELL;
            cur_row  = 0;
            cur_col  = 0;
            failures = 0;
        endfunction

        function void note_request(logic op, tcw_pkg::t_char ch, tcw_pkg::t_row row,
                                   tcw_pkg::t_col col);
            t_console_rsp r;
            r.data = '0;
            if (op == tcw_pkg::OP_PUT) begin
                if (ch != tcw_pkg::CH_NUL) begin
                    // cursor past the bottom: scroll up and blank the last row first
                    if (cur_row >= ROWS) begin
                        for (int i = 0; i < (ROWS-1)*COLS; i++) screen[i] = screen[i+COLS];
                        for (int i = 0; i < COLS; i++)
                            screen[(ROWS-1)*COLS+i] = tcw_pkg::BLANK_CELL;
                        cur_row = ROWS - 1;
                    end
                    if (ch == tcw_pkg::CH_NEWLINE) begin
                        cur_col = 0;
                        cur_row++;
                    end else if (ch != tcw_pkg::CH_RETURN) begin
                        screen[cur_row*COLS+cur_col] = {tcw_pkg::TEXT_ATTR, ch};
                        cur_col++;
                        if (cur_col >= COLS) begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                end
            end else if (row < ROWS && col < COLS) begin
                r.data = screen[row*COLS+col];
            end
            r.pos = tcw_pkg::t_pos'(cur_row*COLS + cur_col);
            awaited_rsp.push_back(r);
        endfunction

        function void check_response(tcw_pkg::t_pos pos, tcw_pkg::t_cell data);
            t_console_rsp e;
            if (awaited_rsp.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected response: cursor_pos %0d cell_data %h", pos, data);
                return;
            end
            e = awaited_rsp.pop_front();
            if (pos !== e.pos || data !== e.data) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: cursor_pos exp %0d got %0d, cell_data exp %h got %h",
                             e.pos, pos, e.data, data);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcw_in_if  req_if ();
    tcw_out_if rsp_if ();

    text_console_writer #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    console_checker sb = new();
    int counted = 0;
    int burst_left = 0;

    always #2 i_clk = ~i_clk;

    // offer one transaction, note it when accepted, then idle between bursts
    task automatic send_item(input logic op, input tcw_pkg::t_char ch,
                             input tcw_pkg::t_row row, input tcw_pkg::t_col col);
        int gap;
        req_if.valid     <= 1'b1;
        req_if.opcode    <= op;
        req_if.character <= ch;
        req_if.read_row  <= row;
        req_if.read_col  <= col;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(op, ch, row, col);
        if (!(op == tcw_pkg::OP_PUT && ch == tcw_pkg::CH_NUL)) counted++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic put_char(input tcw_pkg::t_char ch);
        send_item(tcw_pkg::OP_PUT, ch, tcw_pkg::t_row'($urandom), tcw_pkg::t_col'($urandom));
    endtask

    task automatic read_cell(input int row, input int col);
        send_item(tcw_pkg::OP_READ, tcw_pkg::t_char'($urandom), tcw_pkg::t_row'(row),
                  tcw_pkg::t_col'(col));
    endtask

    // stop offering until every response is back
    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.awaited_rsp.size() != 0) @(posedge i_clk);
    endtask

    function automatic tcw_pkg::t_char pick_glyph();
        tcw_pkg::t_char c;
        do c = tcw_pkg::t_char'($urandom_range(1, 255));
        while (c == tcw_pkg::CH_NEWLINE || c == tcw_pkg::CH_RETURN);
        return c;
    endfunction

    // reads: mostly near the cursor, some anywhere, a few out of range
    task automatic read_somewhere();
        int pick;
        int base;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            base = (sb.cur_row >= ROWS) ? ROWS - 1 : sb.cur_row;
            read_cell(base - $urandom_range(0, (base < 2) ? base : 2),
                      $urandom_range(0, COLS-1));
        end else if (pick < 9) begin
            read_cell($urandom_range(0, ROWS-1), $urandom_range(0, COLS-1));
        end else if ($urandom_range(0, 1) == 0) begin
            read_cell($urandom_range(0, 31), $urandom_range(COLS, 127));
        end else begin
            read_cell($urandom_range(ROWS, 31), $urandom_range(0, 127));
        end
    endtask

    // receiver: ready pattern of its own, with one long hold-off
    initial begin
        int taken;
        int seg_left;
        int mode;
        int hold_left;
        bit held_once;
        taken     = 0;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        held_once = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                sb.check_response(rsp_if.cursor_pos, rsp_if.cell_data);
                taken++;
            end
            if (!held_once && taken == 60) begin
                held_once = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // run limit
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // reset, directed transactions, random text sequences, final verdict
    initial begin
        int kind;
        int n;
        bit paused_mid;
        paused_mid = 1'b0;
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.opcode    <= tcw_pkg::OP_PUT;
        req_if.character <= tcw_pkg::CH_NUL;
        req_if.read_row  <= '0;
        req_if.read_col  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // blank screen corners and out-of-range reads
        read_cell(0, 0);
        read_cell(ROWS-1, COLS-1);
        read_cell(31, 127);
        read_cell(0, COLS);
        read_cell(ROWS, 0);
        // zero byte is ignored, carriage return only checks for scroll
        put_char(tcw_pkg::CH_NUL);
        put_char(8'h41);
        put_char(8'hFF);
        put_char(8'h80);
        put_char(8'h01);
        put_char(tcw_pkg::CH_RETURN);
        read_cell(0, 0);
        read_cell(0, 1);
        put_char(tcw_pkg::CH_NEWLINE);
        put_char(8'h7E);
        read_cell(1, 0);
        read_cell(0, 3);
        put_char(tcw_pkg::CH_NUL);
        drain();

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (!paused_mid && counted >= RANDOM_ITEMS/2) begin
                paused_mid = 1'b1;
                drain();
            end
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                // short line, sometimes ended with a carriage return
                n = $urandom_range(0, 12);
                repeat (n) put_char(pick_glyph());
                if ($urandom_range(0, 4) == 0) put_char(tcw_pkg::CH_RETURN);
                put_char(tcw_pkg::CH_NEWLINE);
            end else if (kind < 55) begin
                // long line that may wrap at the row end
                n = $urandom_range(70, 100);
                repeat (n) put_char(pick_glyph());
                if ($urandom_range(0, 1) == 0) put_char(tcw_pkg::CH_NEWLINE);
            end else if (kind < 75) begin
                n = $urandom_range(1, 8);
                repeat (n) put_char(tcw_pkg::CH_NEWLINE);
            end else if (kind < 90) begin
                n = $urandom_range(1, 4);
                repeat (n) read_somewhere();
            end else begin
                // noise: special bytes and raw reads
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 1) == 0) begin
                        case ($urandom_range(0, 3))
                            0: put_char(tcw_pkg::CH_NUL);
                            1: put_char(tcw_pkg::CH_NEWLINE);
                            2: put_char(tcw_pkg::CH_RETURN);
                            default: put_char(tcw_pkg::t_char'($urandom));
                        endcase
                    end else begin
                        read_cell($urandom_range(0, 31), $urandom_range(0, 127));
                    end
                end
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.failures == 0 && sb.awaited_rsp.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
